[design/tcfd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfd_pkg
// Types and constants shared by the TC transfer frame deframer modules.
// ----------------------------------------------------------------------------
package tcfd_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam int OUT_DATA_W = 80;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_SHORT        = 3'd1,
    ST_RESERVED     = 3'd2,
    ST_LEN_MISMATCH = 3'd3,
    ST_NO_SEG_HDR   = 3'd4
  } tcfd_status_e;

  typedef enum logic [1:0] {
    BK_EMPTY,
    BK_DATA,
    BK_SUMMARY
  } tcfd_back_state_e;

  typedef struct packed {
    logic [1:0]   version_number;
    logic         type_b_flag;
    logic         control_flag;
    logic [9:0]   craft_id;
    logic [5:0]   channel_id;
    logic [9:0]   length_field;
    logic [7:0]   sequence_number;
    logic [7:0]   seg_hdr;
    logic [15:0]  error_control;
    tcfd_status_e status;
  } tcfd_summary_t;

  typedef struct packed {
    logic          has_data;
    logic [7:0]    data_byte;
    logic          has_summary;
    tcfd_summary_t summary;
  } tcfd_entry_t;

endpackage

[design/tcfd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfd_front
// Octet classifier: header capture, data delay line and frame-end summary.
// ----------------------------------------------------------------------------
module tcfd_front import tcfd_pkg::*; #(
  parameter int MAX_FRAME_OCTETS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        seg_enable_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_octet_i,
  input  logic        in_eof_i,
  input  logic        fifo_full_i,
  output logic        push_o,
  output tcfd_entry_t entry_o
);

  localparam int CNT_W = $clog2(MAX_FRAME_OCTETS + 2);
  localparam int CMP_W = (CNT_W > 11) ? CNT_W : 11;
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_FRAME_OCTETS + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d, total;
  logic [39:0]      hdr_q, hdr_d, hdr_n;
  logic [7:0]       seg_q, seg_d;
  logic [15:0]      tail_q, tail_d, tail_n;
  logic             accept, seg, emit;
  logic [9:0]       len;
  tcfd_status_e     status;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    hdr_n = hdr_q;
    case (cnt_q)
      CNT_W'(0): hdr_n[39:32] = in_octet_i;
      CNT_W'(1): hdr_n[31:24] = in_octet_i;
      CNT_W'(2): hdr_n[23:16] = in_octet_i;
      CNT_W'(3): hdr_n[15:8]  = in_octet_i;
      CNT_W'(4): hdr_n[7:0]   = in_octet_i;
      default:   hdr_n = hdr_q;
    endcase
  end

  assign seg    = seg_enable_i && !hdr_n[36];
  assign emit   = cnt_q >= (seg ? CNT_W'(8) : CNT_W'(7));
  assign tail_n = {tail_q[7:0], in_octet_i};
  assign total  = (cnt_q == CNT_SAT) ? cnt_q : cnt_q + CNT_W'(1);
  assign len    = {hdr_n[17:16], hdr_n[15:8]};

  always_comb begin
    if (total < CNT_W'(7)) begin
      status = ST_SHORT;
    end else if (!hdr_n[37] && hdr_n[36]) begin
      status = ST_RESERVED;
    end else if (CMP_W'(len) + CMP_W'(1) != CMP_W'(total)) begin
      status = ST_LEN_MISMATCH;
    end else if (seg && total < CNT_W'(8)) begin
      status = ST_NO_SEG_HDR;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    entry_o                         = '0;
    entry_o.has_data                = emit;
    entry_o.data_byte               = emit ? tail_q[15:8] : 8'd0;
    entry_o.has_summary             = in_eof_i;
    entry_o.summary.version_number  = hdr_n[39:38];
    entry_o.summary.type_b_flag     = hdr_n[37];
    entry_o.summary.control_flag    = hdr_n[36];
    entry_o.summary.craft_id        = {hdr_n[33:32], hdr_n[31:24]};
    entry_o.summary.channel_id      = hdr_n[23:18];
    entry_o.summary.length_field    = len;
    entry_o.summary.sequence_number = hdr_n[7:0];
    entry_o.summary.seg_hdr         = (seg && total >= CNT_W'(8)) ? seg_q : 8'd0;
    entry_o.summary.error_control   = tail_n;
    entry_o.summary.status          = status;
  end

  assign push_o = accept && (emit || in_eof_i);

  always_comb begin
    cnt_d  = cnt_q;
    hdr_d  = hdr_q;
    seg_d  = seg_q;
    tail_d = tail_q;
    if (accept) begin
      if (in_eof_i) begin
        cnt_d  = '0;
        hdr_d  = '0;
        seg_d  = '0;
        tail_d = '0;
      end else begin
        cnt_d  = total;
        hdr_d  = hdr_n;
        tail_d = tail_n;
        if (cnt_q == CNT_W'(5) && seg) begin
          seg_d = in_octet_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      hdr_q  <= '0;
      seg_q  <= '0;
      tail_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      hdr_q  <= hdr_d;
      seg_q  <= seg_d;
      tail_q <= tail_d;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_SAT) else $error("octet counter beyond saturation");

endmodule

[design/tcfd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfd_fifo
// Short queue of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module tcfd_fifo import tcfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  tcfd_entry_t push_entry_i,
  input  logic        pop_i,
  output tcfd_entry_t head_o,
  output logic        full_o,
  output logic        empty_o
);

  tcfd_entry_t           mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + FIFO_PTR_W'(1) : wr_q;
    rd_d  = pop_i ? rd_q + FIFO_PTR_W'(1) : rd_q;
    cnt_d = cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("pop from empty queue");

endmodule

[design/tcfd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfd_back
// Output sequencer: sends an entry's data beat, its summary beat, or the data beat and then the summary beat.
// ----------------------------------------------------------------------------
module tcfd_back import tcfd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcfd_entry_t           head_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  tcfd_back_state_e state_q, state_d;
  tcfd_entry_t      cur_q, cur_d;
  logic             fire, load;

  assign fire = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    case (state_q)
      BK_EMPTY: begin
        load = !empty_i;
      end
      BK_DATA: begin
        if (fire) begin
          if (cur_q.has_summary) begin
            state_d = BK_SUMMARY;
          end else begin
            load = !empty_i;
            if (empty_i) begin
              state_d = BK_EMPTY;
            end
          end
        end
      end
      BK_SUMMARY: begin
        if (fire) begin
          load = !empty_i;
          if (empty_i) begin
            state_d = BK_EMPTY;
          end
        end
      end
      default: begin
        state_d = BK_EMPTY;
      end
    endcase
    if (load) begin
      state_d = head_i.has_data ? BK_DATA : BK_SUMMARY;
    end
    cur_d = load ? head_i : cur_q;
  end

  assign pop_o = load;

  always_comb begin
    out_valid_o = 1'b0;
    out_last_o  = 1'b0;
    out_data_o  = '0;
    case (state_q)
      BK_DATA: begin
        out_valid_o      = 1'b1;
        out_data_o[7:0]  = cur_q.data_byte;
      end
      BK_SUMMARY: begin
        out_valid_o       = 1'b1;
        out_last_o        = 1'b1;
        out_data_o[72:8]  = {cur_q.summary.status,
                             cur_q.summary.error_control,
                             cur_q.summary.seg_hdr,
                             cur_q.summary.sequence_number,
                             cur_q.summary.length_field,
                             cur_q.summary.channel_id,
                             cur_q.summary.craft_id,
                             cur_q.summary.control_flag,
                             cur_q.summary.type_b_flag,
                             cur_q.summary.version_number};
      end
      default: begin
        out_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  a_data_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DATA |-> cur_q.has_data) else $error("data beat without data");

  a_summary_has_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SUMMARY |-> cur_q.has_summary)
    else $error("summary beat without summary");

endmodule

[design/tc_transfer_frame_deframer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tc_transfer_frame_deframer_top
// TC transfer frame deframer with APB control register.
//
// Input stream s_axis carries one frame octet per beat, tlast on the last
// octet. Output stream m_axis carries data octets (tlast low) and, after the
// last data octet of a frame, one summary beat (tlast high) with the header
// fields, segment header, error control field and status. Data octets lag the
// input by two octets; the last two octets only appear as error control.
// On a nonzero status the consumer drops the frame's data octets.
// Throughput is one octet per cycle while m_axis accepts; a frame-end octet that
// also releases a data octet yields both a data beat and a summary beat, and the
// four-entry queue between the classifier and the output sequencer absorbs this.
// An input beat reaches the output through the queue write and the sequencer load.
// When m_axis stalls the queue fills and s_axis_tready drops once it is full.
// Reset clears the frame state and sets the segment header enable (address 0)
// to 1.
// ----------------------------------------------------------------------------
module tc_transfer_frame_deframer_top import tcfd_pkg::*; #(
  parameter int MAX_FRAME_OCTETS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] octet
  input  logic [7:0]            s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] data_byte, [9:8] version_number, [10] type_b_flag, [11] control_flag,
  // [21:12] craft_id, [27:22] channel_id, [37:28] length_field,
  // [45:38] sequence_number, [53:46] seg_hdr, [69:54] error_control,
  // [72:70] status, [79:73] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // is_summary
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic        seg_en_q, seg_en_d;
  logic        push, pop, full, empty;
  tcfd_entry_t push_entry, head;

  assign pready   = 1'b1;
  assign seg_en_d = (psel && penable && pwrite && !paddr[2]) ? pwdata[0] : seg_en_q;
  assign prdata   = paddr[2] ? 32'd0 : {31'd0, seg_en_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_en_q <= 1'b1;
    end else begin
      seg_en_q <= seg_en_d;
    end
  end

  tcfd_front #(
    .MAX_FRAME_OCTETS(MAX_FRAME_OCTETS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seg_enable_i(seg_en_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_octet_i  (s_axis_tdata),
    .in_eof_i    (s_axis_tlast),
    .fifo_full_i (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  tcfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .full_o      (full),
    .empty_o     (empty)
  );

  tcfd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

[tb/sv/tb_tc_transfer_frame_deframer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tc_transfer_frame_deframer_top
// Self-checking testbench for the TC transfer frame deframer.
//
// Frames are fed one octet per beat on s_axis. A scoreboard keeps its own
// octet-serial model of the deframer: header capture, optional segment header,
// the two-octet tail that becomes the error control field, and the frame
// status. Each beat on m_axis is checked field by field against the oldest
// predicted beat. A short directed set covers short frames, the reserved
// bypass/control type, a missing segment header and a register change in the
// middle of a frame. Random frames follow in three idle/stall mixes with the
// segment header enable toggled between them, and a long receiver hold-off
// that backs up the input.
// ----------------------------------------------------------------------------
module tb_tc_transfer_frame_deframer_top import tcfd_pkg::*; ();

  localparam int          MAX_FRAME_OCTETS = 1024;
  localparam int          CYCLE_LIMIT      = 40000;
  localparam int          DRAIN_CYCLES     = 8;
  localparam int          HOLD_CYCLES      = 200;
  localparam int          PHASE_OCTETS     = 235;
  localparam logic [2:0]  SEG_HDR_EN_ADDR  = 3'd0;

  typedef struct {
    bit           is_summary;
    bit [7:0]     data_byte;
    bit [1:0]     version;
    bit           bypass;
    bit           control;
    bit [9:0]     scid;
    bit [5:0]     vcid;
    bit [9:0]     len;
    bit [7:0]     seq;
    bit [7:0]     seg_hdr;
    bit [15:0]    ecf;
    tcfd_status_e status;
  } deframe_beat_t;

  class frame_scoreboard;
    bit            seg_en;
    bit [10:0]     octet_count;
    bit [39:0]     hdr_octets;
    bit [7:0]      seg_octet;
    bit [15:0]     tail;
    deframe_beat_t pending_q[$];
    int            errors;
    int            checked;
    int            frames;
    int            status_seen[5];

    function new();
      seg_en = 1'b1;
      clear_frame();
    endfunction

    function void clear_frame();
      octet_count = '0;
      hdr_octets  = '0;
      seg_octet   = '0;
      tail        = '0;
    endfunction

    function deframe_beat_t blank();
      deframe_beat_t r;
      r.is_summary = 1'b0;
      r.data_byte  = '0;
      r.version    = '0;
      r.bypass     = 1'b0;
      r.control    = 1'b0;
      r.scid       = '0;
      r.vcid       = '0;
      r.len        = '0;
      r.seq        = '0;
      r.seg_hdr    = '0;
      r.ecf        = '0;
      r.status     = ST_OK;
      return r;
    endfunction

    function string fmt(deframe_beat_t r);
      return $sformatf({"last=%0d data=%h ver=%0d byp=%0d ctl=%0d scid=%h vcid=%h ",
                        "len=%h seq=%h seg=%h ecf=%h st=%0d"},
                       r.is_summary, r.data_byte, r.version, r.bypass, r.control,
                       r.scid, r.vcid, r.len, r.seq, r.seg_hdr, r.ecf, r.status);
    endfunction

    function void note_mismatch(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void note_octet(bit [7:0] oct, bit eof);
      deframe_beat_t r;
      bit            seg;
      int            cnt;
      int            total;
      int            data_start;
      cnt = octet_count;
      if (cnt < 5) hdr_octets[8*(4-cnt) +: 8] = oct;
      seg        = seg_en && !hdr_octets[36];
      data_start = seg ? 6 : 5;
      if (cnt == 5 && seg) seg_octet = oct;
      if (cnt >= 2 && cnt - 2 >= data_start) begin
        r = blank();
        r.data_byte = tail[15:8];
        pending_q.push_back(r);
      end
      tail  = {tail[7:0], oct};
      total = (cnt + 1 > MAX_FRAME_OCTETS + 1) ? MAX_FRAME_OCTETS + 1 : cnt + 1;
      if (!eof) begin
        octet_count = 11'(total);
        return;
      end
      r = blank();
      r.is_summary = 1'b1;
      r.version    = hdr_octets[39:38];
      r.bypass     = hdr_octets[37];
      r.control    = hdr_octets[36];
      r.scid       = hdr_octets[33:24];
      r.vcid       = hdr_octets[23:18];
      r.len        = hdr_octets[17:8];
      r.seq        = hdr_octets[7:0];
      r.seg_hdr    = (seg && total >= 8) ? seg_octet : 8'h00;
      r.ecf        = tail;
      if (total < 7)                      r.status = ST_SHORT;
      else if (!r.bypass && r.control)    r.status = ST_RESERVED;
      else if (int'(r.len) + 1 != total)  r.status = ST_LEN_MISMATCH;
      else if (seg && total < 8)          r.status = ST_NO_SEG_HDR;
      else                                r.status = ST_OK;
      pending_q.push_back(r);
      status_seen[int'(r.status)]++;
      frames++;
      clear_frame();
    endfunction

    function bit same(deframe_beat_t a, deframe_beat_t b);
      return a.is_summary == b.is_summary && a.data_byte == b.data_byte &&
             a.version == b.version && a.bypass == b.bypass &&
             a.control == b.control && a.scid == b.scid && a.vcid == b.vcid &&
             a.len == b.len && a.seq == b.seq && a.seg_hdr == b.seg_hdr &&
             a.ecf == b.ecf && a.status == b.status;
    endfunction

    function void check_beat(logic last, logic [OUT_DATA_W-1:0] d);
      deframe_beat_t got;
      deframe_beat_t want;
      got.is_summary = last;
      got.data_byte  = d[7:0];
      got.version    = d[9:8];
      got.bypass     = d[10];
      got.control    = d[11];
      got.scid       = d[21:12];
      got.vcid       = d[27:22];
      got.len        = d[37:28];
      got.seq        = d[45:38];
      got.seg_hdr    = d[53:46];
      got.ecf        = d[69:54];
      got.status     = tcfd_status_e'(d[72:70]);
      checked++;
      if (pending_q.size() == 0) begin
        note_mismatch($sformatf("unexpected beat %s", fmt(got)));
        return;
      end
      want = pending_q.pop_front();
      if (!same(want, got) || $isunknown({last, d}) || d[79:73] != '0)
        note_mismatch($sformatf("beat %0d expected %s got %s pad=%h", checked,
                                fmt(want), fmt(got), d[79:73]));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // [7:0] octet
  logic [7:0]            s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [7:0] data_byte, [9:8] version_number, [10] type_b_flag, [11] control_flag,
  // [21:12] craft_id, [27:22] channel_id, [37:28] length_field,
  // [45:38] sequence_number, [53:46] seg_hdr, [69:54] error_control,
  // [72:70] status, [79:73] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // is_summary
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  frame_scoreboard sb;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              octets_sent   = 0;
  bit              hold_go       = 1'b0;
  logic            hold_active   = 1'b0;

  tc_transfer_frame_deframer_top #(
    .MAX_FRAME_OCTETS(MAX_FRAME_OCTETS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= hold_active ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // long receiver hold-off
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_octet(s_axis_tdata, s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tlast, m_axis_tdata);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("tb_tc_transfer_frame_deframer_top: errors");
    $finish;
  end

  task automatic send_beat(input logic [7:0] oct, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= oct;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    octets_sent++;
  endtask

  // octets from..upto-1 of a frame of total octets, header first
  task automatic send_frame_part(input bit [39:0] hdr, input int from, input int upto,
                                 input int total);
    for (int i = from; i < upto; i++)
      send_beat(i < 5 ? hdr[8*(4-i) +: 8] : 8'($urandom_range(255)), i == total - 1);
  endtask

  function automatic bit [39:0] random_header(int n, bit clean);
    bit [39:0] h;
    h = {8'($urandom_range(255)), 32'($urandom)};
    if (clean) begin
      h[17:8] = (n > MAX_FRAME_OCTETS) ? 10'h3FF : 10'(n - 1);
      if (h[37:36] == 2'b01) h[37] = 1'b1;
    end
    return h;
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_seg_hdr_enable(input bit v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEG_HDR_EN_ADDR;
    pwdata  <= {31'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.seg_en = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {31'b0, v})
      sb.note_mismatch($sformatf("register readback expected %h got %h", {31'b0, v}, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_frames(input int budget);
    int start;
    int r;
    int n;
    start = octets_sent;
    while (octets_sent - start < budget) begin
      r = $urandom_range(99);
      if (r < 70)      n = $urandom_range(24, 7);
      else if (r < 88) n = $urandom_range(64, 25);
      else             n = $urandom_range(8, 1);
      send_frame_part(random_header(n, $urandom_range(99) < 75), 0, n, n);
    end
  endtask

  initial begin
    sb = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames, segment header enable at its reset value
    send_frame_part(40'hFF_00_00_00_00, 0, 1, 1);
    send_frame_part(40'h00_00_00_06_00, 0, 7, 7);
    send_frame_part(40'hDF_FF_FC_06_FF, 0, 7, 7);
    wait_drained();
    set_seg_hdr_enable(1'b0);
    // enable flips between the header and the segment octet
    send_frame_part(40'hEF_FF_FC_08_FF, 0, 5, 9);
    wait_drained();
    set_seg_hdr_enable(1'b1);
    send_frame_part(40'hEF_FF_FC_08_FF, 5, 9, 9);
    wait_drained();

    send_idle_pct = 21;
    recv_idle_pct = 80;
    set_seg_hdr_enable(1'b1);
    random_frames(PHASE_OCTETS);
    wait_drained();

    send_idle_pct = 80;
    recv_idle_pct = 21;
    set_seg_hdr_enable(1'b0);
    random_frames(PHASE_OCTETS);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_seg_hdr_enable(1'b1);
    hold_go = 1'b1;
    random_frames(PHASE_OCTETS);
    wait_drained();

    if (sb.pending_q.size() != 0)
      sb.note_mismatch($sformatf("%0d predicted beats never came", sb.pending_q.size()));
    $display("run covered %0d frames in %0d octets, %0d output beats checked",
             sb.frames, octets_sent, sb.checked);
    $display("frame status mix: ok %0d, short %0d, reserved %0d, length %0d, no seg hdr %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4]);
    if (sb.errors == 0) begin
      $display("tb_tc_transfer_frame_deframer_top: clean");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("tb_tc_transfer_frame_deframer_top: errors");
    end
    $finish;
  end

endmodule
